// ----- design/amf_pkg.sv -----
// Package for the ALU / multiply block with status flags.
// Holds the item structs, flag struct, opcode, action and flag-kind codes.
// No dependencies.
`timescale 1ns / 1ps

package amf_pkg;

    typedef enum logic [1:0] {
        ACT_ALU = 2'd0,
        ACT_MUL = 2'd1,
        ACT_MLA = 2'd2,
        ACT_BAD = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        OP_AND  = 4'h0,
        OP_XOR  = 4'h1,
        OP_SUB  = 4'h2,
        OP_RSB  = 4'h3,
        OP_ADD  = 4'h4,
        OP_ADC  = 4'h5,
        OP_SBC  = 4'h6,
        OP_RSC  = 4'h7,
        OP_CAND = 4'h8,
        OP_CXOR = 4'h9,
        OP_CSUB = 4'ha,
        OP_CADD = 4'hb,
        OP_OR   = 4'hc,
        OP_MOV  = 4'hd,
        OP_CLR  = 4'he,
        OP_MVN  = 4'hf
    } alu_op_t;

    // Which flags an operation updates
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_LOGIC = 2'd1,
        KIND_ARITH = 2'd2,
        KIND_MUL   = 2'd3
    } kind_t;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } flags_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  alu_op;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
        logic [31:0] addend;
        logic        set_flags;
    } req_t;

    typedef struct packed {
        logic [31:0] result;
        logic        flag_n;
        logic        flag_z;
        logic        flag_c;
        logic        flag_v;
        logic        illegal;
    } rsp_t;

endpackage

// ----- design/alu_multiply_with_status_flags.sv -----
// ALU / multiply block with N, Z, C, V status flags: input register, execute
// logic, result register. An accepted item is held in the input register, then
// its result is registered into the result register once that stage is free;
// throughput one item per cycle while results are taken, with the status flags
// fed back around the execute stage. Reset (rst_n low, asynchronous) empties both
// stages and clears all flags. Uses amf_pkg and amf_exec.
`timescale 1ns / 1ps

module alu_multiply_with_status_flags (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  amf_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output amf_pkg::rsp_t rsp
);
    import amf_pkg::*;

    req_t   s1_reg;
    logic   s1_valid_reg;
    rsp_t   rsp_reg;
    logic   rsp_valid_reg;
    flags_t flags_reg;
    flags_t flags_next;
    rsp_t   exec_rsp;
    logic   out_free;
    logic   advance;
    logic   accept;

    // Handshake: the result stage frees when empty or taken
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign advance   = s1_valid_reg && out_free;
    assign req_ready = !s1_valid_reg || out_free;
    assign accept    = req_valid && req_ready;

    amf_exec u_exec (
        .req        (s1_reg),
        .flags      (flags_reg),
        .rsp        (exec_rsp),
        .flags_next (flags_next)
    );

    // Stage valid bits and status flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            if (req_ready)
                s1_valid_reg <= req_valid;
            if (out_free)
                rsp_valid_reg <= s1_valid_reg;
            if (advance)
                flags_reg <= flags_next;
        end
    end

    // Capture payloads
    always_ff @(posedge clk)
    begin
        if (accept)
            s1_reg <= req;
        if (advance)
            rsp_reg <= exec_rsp;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef NO_ASSERTIONS
    // A waiting result shows the live flag state
    a_rsp_flags: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_reg.flag_n == flags_reg.n && rsp_reg.flag_z == flags_reg.z
                           && rsp_reg.flag_c == flags_reg.c && rsp_reg.flag_v == flags_reg.v))
        else $error("result flags differ from status flags");

    // A rejected item leaves the flags alone
    a_illegal_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && exec_rsp.illegal) |=> $stable(flags_reg))
        else $error("illegal item changed flags");

    // Without set_flags the flags hold
    a_noset_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !s1_reg.set_flags) |=> $stable(flags_reg))
        else $error("flags changed without set_flags");

    // Flag-setting multiply clears carry
    a_mul_clear_c: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_reg.set_flags && !exec_rsp.illegal
         && (s1_reg.action == ACT_MUL || s1_reg.action == ACT_MLA)) |=> !flags_reg.c)
        else $error("multiply left carry set");

    // Input stalls only behind a held item
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> (s1_valid_reg && rsp_valid_reg))
        else $error("input stalled with free stage");
`endif

endmodule

// ----- design/amf_exec.sv -----
// Execute datapath: ALU, 32-bit multiply / multiply-add and flag update.
// Purely combinational; uses amf_pkg.
`timescale 1ns / 1ps

module amf_exec (
    input  amf_pkg::req_t   req,
    input  amf_pkg::flags_t flags,
    output amf_pkg::rsp_t   rsp,
    output amf_pkg::flags_t flags_next
);
    import amf_pkg::*;

    alu_op_t     op;
    action_t     act;
    logic [31:0] add_x;
    logic [31:0] add_y;
    logic        add_cin;
    logic [32:0] sum;
    logic [31:0] low_sum;
    logic        add_c;
    logic        add_v;
    logic [31:0] prod;
    logic [31:0] res;
    kind_t       kind;
    logic        bad;

    // Select adder operands; subtraction adds the inverted subtrahend
    always_comb
    begin
        op = alu_op_t'(req.alu_op);
        add_x   = req.operand_a;
        add_y   = req.operand_b;
        add_cin = 1'b0;
        unique case (op)
            OP_SUB, OP_CSUB:
            begin
                add_y   = ~req.operand_b;
                add_cin = 1'b1;
            end
            OP_RSB:
            begin
                add_x   = req.operand_b;
                add_y   = ~req.operand_a;
                add_cin = 1'b1;
            end
            OP_ADC:
            begin
                add_cin = flags.c;
            end
            OP_SBC:
            begin
                add_y   = ~req.operand_b;
                add_cin = flags.c;
            end
            OP_RSC:
            begin
                add_x   = req.operand_b;
                add_y   = ~req.operand_a;
                add_cin = flags.c;
            end
            default:
            begin
                add_cin = 1'b0;
            end
        endcase
    end

    // Add with carry out of bit 31 and out of bit 30 for overflow
    assign sum     = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_cin};
    assign low_sum = {1'b0, add_x[30:0]} + {1'b0, add_y[30:0]} + {31'd0, add_cin};
    assign add_c   = sum[32];
    assign add_v   = sum[32] ^ low_sum[31];

    // Low half of the product only
    assign prod = req.operand_a * req.operand_b;

    // Pick the result and the flag class
    always_comb
    begin
        act  = action_t'(req.action);
        res  = '0;
        kind = KIND_NONE;
        bad  = 1'b0;
        unique case (act)
            ACT_ALU:
            begin
                unique case (op)
                    OP_AND, OP_CAND:
                    begin
                        res  = req.operand_a & req.operand_b;
                        kind = KIND_LOGIC;
                    end
                    OP_XOR, OP_CXOR:
                    begin
                        res  = req.operand_a ^ req.operand_b;
                        kind = KIND_LOGIC;
                    end
                    OP_SUB, OP_RSB, OP_ADD, OP_ADC, OP_SBC, OP_RSC, OP_CSUB, OP_CADD:
                    begin
                        res  = sum[31:0];
                        kind = KIND_ARITH;
                    end
                    OP_OR:
                    begin
                        res  = req.operand_a | req.operand_b;
                        kind = KIND_LOGIC;
                    end
                    OP_MOV:
                    begin
                        res  = req.operand_b;
                        kind = KIND_NONE;
                    end
                    OP_CLR:
                    begin
                        res  = req.operand_a & ~req.operand_b;
                        kind = KIND_LOGIC;
                    end
                    OP_MVN:
                    begin
                        res  = ~req.operand_b;
                        kind = KIND_NONE;
                    end
                endcase
                // Compare forms need set_flags
                bad = (op == OP_CAND || op == OP_CXOR || op == OP_CSUB || op == OP_CADD)
                      && !req.set_flags;
            end
            ACT_MUL:
            begin
                res  = prod;
                kind = KIND_MUL;
            end
            ACT_MLA:
            begin
                res  = prod + req.addend;
                kind = KIND_MUL;
            end
            ACT_BAD:
            begin
                bad = 1'b1;
            end
        endcase
    end

    // Update flags; a rejected item leaves them as they are
    always_comb
    begin
        flags_next = flags;
        if (!bad && req.set_flags && kind != KIND_NONE)
        begin
            flags_next.n = res[31];
            flags_next.z = (res == 32'd0);
            if (kind == KIND_ARITH)
            begin
                flags_next.c = add_c;
                flags_next.v = add_v;
            end
            else if (kind == KIND_MUL)
            begin
                flags_next.c = 1'b0;
            end
        end
    end

    // Build the result item
    always_comb
    begin
        rsp.result  = bad ? 32'd0 : res;
        rsp.flag_n  = flags_next.n;
        rsp.flag_z  = flags_next.z;
        rsp.flag_c  = flags_next.c;
        rsp.flag_v  = flags_next.v;
        rsp.illegal = bad;
    end

endmodule
